>>> src/mvgd_pkg.sv
package mvgd_pkg;

    typedef enum logic [1:0] {
        MODE_EVAL      = 2'd0,
        MODE_LOAD_MEAN = 2'd1,
        MODE_LOAD_ROW  = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    localparam int ELEM_W       = 16;
    localparam int DX_W         = ELEM_W + 1;
    localparam int PROD_W       = ELEM_W + DX_W;
    localparam int NUM_ELEMS    = 4;
    localparam int EXP_DEPTH    = 64;
    localparam int EXP_IDX_W    = 6;
    localparam int EXP_ENTRY_W  = 17;
    localparam int NORM_W       = 32;
    localparam logic [NORM_W-1:0] NORM_RESET = 32'd1660;
    localparam logic [15:0] HALF_LOG2E_Q16 = 16'd47274;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam int SHIFT_ZERO   = 48;

    typedef logic [EXP_ENTRY_W-1:0] exp_rom_t [EXP_DEPTH];

    // Entry k holds 2^(-k/EXP_DEPTH) in Q1.16, from a truncated Taylor series of exp(-z).
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t   rom;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            z = (64'(k) * LN2_Q32) / 64'(EXP_DEPTH);
            term = 64'd1 << 32;
            sum = term;
            for (int i = 1; i <= 20; i++) begin
                term = ((term * z) >> 32) / 64'(i);
                if ((i % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rom[k] = EXP_ENTRY_W'((sum + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> src/mvgd_lane.sv
module mvgd_lane import mvgd_pkg::*; #(
    parameter int DIM = 4,
    parameter int ACC_W = 36,
    parameter int QI_W = 53
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [DX_W-1:0]          dx [DIM],
    input  logic signed [DX_W-1:0]          dx_self,
    input  logic signed [ELEM_W-1:0]        row [DIM],
    output logic signed [QI_W-1:0]          qi
);

    logic signed [PROD_W-1:0] p_reg [DIM];
    logic signed [DX_W-1:0]   dx1_reg;
    logic signed [DX_W-1:0]   dx2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [QI_W-1:0]   qi_reg;

    always_comb begin
        acc_next = '0;
        for (int j = 0; j < DIM; j++) begin
            acc_next = acc_next + ACC_W'(p_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < DIM; j++) begin
                p_reg[j] <= PROD_W'(row[j]) * PROD_W'(dx[j]);
            end
            dx1_reg <= dx_self;
            acc_reg <= acc_next;
            dx2_reg <= dx1_reg;
            qi_reg  <= QI_W'(dx2_reg) * QI_W'(acc_reg);
        end
    end

    assign qi = qi_reg;

endmodule

>>> src/mvgd_merge.sv
module mvgd_merge import mvgd_pkg::*; #(
    parameter int DIM = 4,
    parameter int QI_W = 53,
    parameter int Q_W = 56
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [QI_W-1:0]   qi [DIM],
    input  logic [NORM_W-1:0]        norm_factor,
    output logic [31:0]              density,
    output logic                     saturated
);

    logic signed [Q_W-1:0] q_sum;
    logic [Q_W-1:0]        uq;
    logic [31:0]           lo_reg;
    logic                  big4_reg, sat4_reg;
    logic [31:0]           t_reg;
    logic                  big5_reg, sat5_reg;
    logic [47:0]           t_full;
    logic [15:0]           n_int;
    logic [EXP_IDX_W-1:0]  idx;
    logic [NORM_W+EXP_ENTRY_W-1:0] prod_reg;
    logic [5:0]            sh_reg;
    logic                  zero6_reg, sat6_reg;
    logic [NORM_W+EXP_ENTRY_W-1:0] shifted;
    logic [31:0]           dens_reg;
    logic                  sat7_reg;

    always_comb begin
        q_sum = '0;
        for (int i = 0; i < DIM; i++) begin
            q_sum = q_sum + Q_W'(qi[i]);
        end
        uq = q_sum[Q_W-1] ? '0 : q_sum;
        t_full = 48'(lo_reg) * 48'(HALF_LOG2E_Q16);
        n_int = t_reg[31:16];
        idx = t_reg[15:16-EXP_IDX_W];
        shifted = (prod_reg >> 16) >> sh_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg    <= uq[39:8];
            big4_reg  <= |uq[Q_W-1:40];
            sat4_reg  <= q_sum[Q_W-1];
            t_reg     <= t_full[47:16];
            big5_reg  <= big4_reg;
            sat5_reg  <= sat4_reg;
            prod_reg  <= (NORM_W+EXP_ENTRY_W)'(norm_factor) *
                         (NORM_W+EXP_ENTRY_W)'(EXP_ROM[idx]);
            sh_reg    <= n_int[5:0];
            zero6_reg <= big5_reg || (n_int >= 16'(SHIFT_ZERO));
            sat6_reg  <= sat5_reg;
            dens_reg  <= zero6_reg ? '0 : shifted[31:0];
            sat7_reg  <= sat6_reg;
        end
    end

    assign density   = dens_reg;
    assign saturated = sat7_reg;

endmodule

>>> src/multivariate_gaussian_density.sv
// Gaussian density evaluator: load items (mode 1 mean, mode 2 one inverse covariance row, Q8.8)
// update the stored parameters at once and give no result; an evaluate item (mode 0) gives
// density = norm_factor * exp(-q/2) in Q16.16, with saturated set when the quadratic form came
// out negative and was clipped to zero. One item is taken every cycle while not held: one lane
// per vector element forms its row product and term of the quadratic form, and a merging
// pipeline sums the terms and evaluates the exponential through a shift and a 64-entry table.
// The whole pipeline holds while a result waits on the output and m_ready is low. The user must
// write norm_factor through the cfg port while no evaluation is in flight; it is not enforced.
module multivariate_gaussian_density import mvgd_pkg::*; #(
    parameter int DIM = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [1:0]               s_row_index,
    input  logic signed [15:0]       s_elem0,
    input  logic signed [15:0]       s_elem1,
    input  logic signed [15:0]       s_elem2,
    input  logic signed [15:0]       s_elem3,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_density,
    output logic                     m_saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [31:0]              cfg_data
);

    localparam int ACC_W = PROD_W + $clog2(DIM + 1);
    localparam int QI_W  = DX_W + ACC_W;
    localparam int Q_W   = QI_W + $clog2(DIM + 1);
    localparam int LAT   = 7;

    logic [NORM_W-1:0]        norm_reg;
    logic signed [ELEM_W-1:0] mean_reg [DIM];
    logic signed [ELEM_W-1:0] inv_reg  [DIM][DIM];
    logic signed [ELEM_W-1:0] vec      [DIM];
    logic signed [ELEM_W-1:0] in_elems [NUM_ELEMS];
    logic signed [DX_W-1:0]   dx       [DIM];
    logic signed [QI_W-1:0]   qi       [DIM];
    logic [LAT-1:0]           vld_reg;
    logic                     en;
    logic                     take;
    mode_t                    mode;

    assign in_elems[0] = s_elem0;
    assign in_elems[1] = s_elem1;
    assign in_elems[2] = s_elem2;
    assign in_elems[3] = s_elem3;

    assign mode    = mode_t'(s_mode);
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign take    = s_valid && en;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            vec[i] = (i < NUM_ELEMS) ? in_elems[i % NUM_ELEMS] : '0;
            dx[i]  = DX_W'(vec[i]) - DX_W'(mean_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg <= NORM_RESET;
            vld_reg  <= '0;
            for (int i = 0; i < DIM; i++) begin
                mean_reg[i] <= '0;
                for (int j = 0; j < DIM; j++) begin
                    inv_reg[i][j] <= (i == j) ? 16'sd256 : 16'sd0;
                end
            end
        end else begin
            if (cfg_valid) begin
                norm_reg <= cfg_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], take && (mode == MODE_EVAL)};
            end
            if (take && (mode == MODE_LOAD_MEAN)) begin
                for (int i = 0; i < DIM; i++) begin
                    mean_reg[i] <= vec[i];
                end
            end
            if (take && (mode == MODE_LOAD_ROW)) begin
                for (int i = 0; i < DIM; i++) begin
                    if (int'(s_row_index) == i) begin
                        for (int j = 0; j < DIM; j++) begin
                            inv_reg[i][j] <= vec[j];
                        end
                    end
                end
            end
        end
    end

    for (genvar g = 0; g < DIM; g++) begin : g_lane
        mvgd_lane #(
            .DIM   (DIM),
            .ACC_W (ACC_W),
            .QI_W  (QI_W)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .dx      (dx),
            .dx_self (dx[g]),
            .row     (inv_reg[g]),
            .qi      (qi[g])
        );
    end

    mvgd_merge #(
        .DIM  (DIM),
        .QI_W (QI_W),
        .Q_W  (Q_W)
    ) u_merge (
        .aclk        (aclk),
        .en          (en),
        .qi          (qi),
        .norm_factor (norm_reg),
        .density     (m_density),
        .saturated   (m_saturated)
    );

    assign m_valid = vld_reg[LAT-1];

endmodule

>>> src/mvgd_checker.sv
module mvgd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_density,
    input logic        m_saturated
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_density) && $stable(m_saturated))
        else $error("Result changed before its transfer.");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow the output side.");

    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_ready))
        else $error("Result appeared while the pipeline was held.");

endmodule

bind multivariate_gaussian_density mvgd_checker u_mvgd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_density   (m_density),
    .m_saturated (m_saturated)
);
